FILE: rtl/tilt_kalman_gyro_bias_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef TILT_KALMAN_GYRO_BIAS_UNIT_DEFINES_SVH
`define TILT_KALMAN_GYRO_BIAS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KGB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KGB_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/kgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kgb_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned ACC_BITS  = 25;
  localparam int unsigned GYR_BITS  = 28;
  localparam int unsigned DT_BITS   = 17;
  localparam int unsigned REG_BITS  = 31;
  localparam int unsigned OUT_BITS  = 32;
  localparam int unsigned IDX_BITS  = 2;

  localparam logic [IDX_BITS-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_MEASURE_NOISE = 2'd1;

  localparam logic [REG_BITS-1:0] PROCESS_NOISE_RST = 31'd66;
  localparam logic [REG_BITS-1:0] MEASURE_NOISE_RST = 31'd1966;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,
    ST_MRATE,
    ST_ANG,
    ST_P33DT,
    ST_P11A,
    ST_P11B,
    ST_P11C,
    ST_COV,
    ST_DEN,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_DIV,
    ST_CORR,
    ST_ANG2,
    ST_INNOV,
    ST_RATE2,
    ST_BIAS,
    ST_POST1,
    ST_POST2,
    ST_POST3,
    ST_POST4,
    ST_POST5,
    ST_OUT
  } step_t;

endpackage
`default_nettype wire

FILE: rtl/kgb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface kgb_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [kgb_pkg::ACC_BITS-1:0] accel_angle;
  logic signed [kgb_pkg::GYR_BITS-1:0] gyro_rate;
  logic        [kgb_pkg::DT_BITS-1:0]  time_step;

  modport source(output valid, accel_angle, gyro_rate, time_step, input ready);
  modport sink(input valid, accel_angle, gyro_rate, time_step, output ready);
endinterface
`default_nettype wire

FILE: rtl/kgb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface kgb_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kgb_pkg::OUT_BITS-1:0] angle_estimate;
  logic signed [kgb_pkg::OUT_BITS-1:0] rate_estimate;

  modport source(output valid, angle_estimate, rate_estimate, input ready);
  modport sink(input valid, angle_estimate, rate_estimate, output ready);
endinterface
`default_nettype wire

FILE: rtl/tilt_kalman_gyro_bias_unit.sv
// One item is processed at a time: a new item is accepted only in the idle state.
// A result can wait in the output register while the next item is taken.
// A bit-serial divider forms the three gains one quotient bit per cycle while
// no noise register is being written.
// Reset (synchronous, active high) restores the noise registers and filter state.
`timescale 1ns / 1ps
`default_nettype none
module tilt_kalman_gyro_bias_unit #(
  parameter int unsigned WORD_BITS = kgb_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = kgb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  kgb_in_if.sink                             in_ch,
  kgb_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [kgb_pkg::IDX_BITS-1:0]  cfg_idx,
  input  wire logic [kgb_pkg::REG_BITS-1:0]  cfg_data
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned IW = W + 9;
  localparam int unsigned MW = 2 * W + 1;
  localparam int unsigned NW = W + F;
  localparam int unsigned CW = $clog2(NW + 1);

  localparam logic signed [IW-1:0] WMAX_X = {{(IW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [IW-1:0] WMIN_X = {{(IW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [IW-1:0] ONE_X  = {{(IW-1){1'b0}}, 1'b1} <<< F;
  localparam logic signed [IW-1:0] OMAX_X = {{(IW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [IW-1:0] OMIN_X = {{(IW-31){1'b1}}, {31{1'b0}}};
  localparam logic [MW-1:0] LIM_POS = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [MW-1:0] LIM_NEG = {{(MW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [MW-1:0] HALF    = {{(MW-1){1'b0}}, 1'b1} << (F - 1);

  function automatic logic signed [IW-1:0] ext(input logic signed [W-1:0] v);
    return {{(IW-W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] r;
    r = v;
    if (v > WMAX_X) r = WMAX_X;
    if (v < WMIN_X) r = WMIN_X;
    return r[W-1:0];
  endfunction

  function automatic logic signed [kgb_pkg::OUT_BITS-1:0] out_sat(
      input logic signed [W-1:0] v);
    logic signed [IW-1:0] r;
    r = ext(v);
    if (r > OMAX_X) r = OMAX_X;
    if (r < OMIN_X) r = OMIN_X;
    return r[kgb_pkg::OUT_BITS-1:0];
  endfunction

  function automatic logic signed [W-1:0] sgn_lim(input logic [MW-1:0] m, input logic neg);
    logic [MW-1:0] r;
    r = m;
    if (neg && m > LIM_NEG) r = LIM_NEG;
    if (!neg && m > LIM_POS) r = LIM_POS;
    return neg ? -$signed(r[W-1:0]) : $signed(r[W-1:0]);
  endfunction

  kgb_pkg::step_t state, state_next, div_ret;

  logic [kgb_pkg::REG_BITS-1:0] q_reg, r_reg;
  logic signed [W-1:0] angle, bias, p11, p13, p31, p33;
  logic signed [W-1:0] rate, p21, p33dt, k1, k2, k3, innov, omk;
  logic        [W-1:0] den;
  logic signed [kgb_pkg::ACC_BITS-1:0] acc;
  logic signed [kgb_pkg::GYR_BITS-1:0] gyr;
  logic        [kgb_pkg::DT_BITS-1:0]  dt;

  logic signed [W-1:0]   ma, mb;
  logic signed [2*W-1:0] prod;
  logic        [2*W-1:0] pmag;
  logic        [MW-1:0]  rsum;
  logic signed [W-1:0]   mr;

  logic [NW-1:0] num, quo;
  logic [W-1:0]  rem;
  logic          div_neg;
  logic [CW-1:0] cnt;
  logic [W:0]    rem2;
  logic [W+1:0]  diff;
  logic          qbit;
  logic signed [W-1:0] kres;

  logic signed [W-1:0] qv, rv, dtw, acc_err, div_src, dsum;
  logic [W-1:0] div_mag;
  logic out_load, cfg_hit;

  assign qv  = sat_w({{(IW-kgb_pkg::REG_BITS){1'b0}}, q_reg});
  assign rv  = sat_w({{(IW-kgb_pkg::REG_BITS){1'b0}}, r_reg});
  assign dtw = {{(W-kgb_pkg::DT_BITS){1'b0}}, dt};
  assign acc_err = sat_w({{(IW-kgb_pkg::ACC_BITS){acc[kgb_pkg::ACC_BITS-1]}}, acc}
                         - ext(angle));

  assign pmag = prod[2*W-1] ? -prod : prod;
  assign rsum = {1'b0, pmag} + HALF;
  assign mr   = sgn_lim(rsum >> F, prod[2*W-1]);

  assign rem2 = {rem, num[NW-1]};
  assign diff = {1'b0, rem2} - {2'b00, den};
  assign qbit = !diff[W+1];
  assign kres = sgn_lim({{(MW-NW){1'b0}}, quo[NW-2:0], qbit}, div_neg);

  assign cfg_hit = cfg_we && (cfg_idx == kgb_pkg::REG_PROCESS_NOISE ||
                              cfg_idx == kgb_pkg::REG_MEASURE_NOISE);
  assign out_load = (state == kgb_pkg::ST_OUT) && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = (state == kgb_pkg::ST_IDLE);

  always_comb begin
    div_src = p11;
    case (state)
      kgb_pkg::ST_K2: div_src = p21;
      kgb_pkg::ST_K3: div_src = p31;
      default: div_src = p11;
    endcase
    div_mag = div_src[W-1] ? -div_src : div_src;
    dsum = sat_w(ext(p11) + ext(rv));
  end

  always_comb begin
    ma = p33;
    mb = dtw;
    case (state)
      kgb_pkg::ST_MRATE: begin ma = rate;  mb = dtw;     end
      kgb_pkg::ST_ANG:   begin ma = p33;   mb = dtw;     end
      kgb_pkg::ST_P33DT: begin ma = p31;   mb = dtw;     end
      kgb_pkg::ST_P11A:  begin ma = p33dt; mb = dtw;     end
      kgb_pkg::ST_P11B:  begin ma = p13;   mb = dtw;     end
      kgb_pkg::ST_CORR:  begin ma = k1;    mb = acc_err; end
      kgb_pkg::ST_RATE2: begin ma = k2;    mb = innov;   end
      kgb_pkg::ST_BIAS:  begin ma = k3;    mb = innov;   end
      kgb_pkg::ST_POST1: begin ma = omk;   mb = p11;     end
      kgb_pkg::ST_POST2: begin ma = omk;   mb = p13;     end
      kgb_pkg::ST_POST3: begin ma = p11;   mb = k3;      end
      kgb_pkg::ST_POST4: begin ma = p13;   mb = k3;      end
      default:           begin ma = p33;   mb = dtw;     end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      kgb_pkg::ST_IDLE:  if (in_ch.valid) state_next = kgb_pkg::ST_RATE;
      kgb_pkg::ST_RATE:  state_next = kgb_pkg::ST_MRATE;
      kgb_pkg::ST_MRATE: state_next = kgb_pkg::ST_ANG;
      kgb_pkg::ST_ANG:   state_next = kgb_pkg::ST_P33DT;
      kgb_pkg::ST_P33DT: state_next = kgb_pkg::ST_P11A;
      kgb_pkg::ST_P11A:  state_next = kgb_pkg::ST_P11B;
      kgb_pkg::ST_P11B:  state_next = kgb_pkg::ST_P11C;
      kgb_pkg::ST_P11C:  state_next = kgb_pkg::ST_COV;
      kgb_pkg::ST_COV:   state_next = kgb_pkg::ST_DEN;
      kgb_pkg::ST_DEN:   state_next = kgb_pkg::ST_K1;
      kgb_pkg::ST_K1:    state_next = kgb_pkg::ST_DIV;
      kgb_pkg::ST_K2:    state_next = kgb_pkg::ST_DIV;
      kgb_pkg::ST_K3:    state_next = kgb_pkg::ST_DIV;
      kgb_pkg::ST_DIV:   if (cnt == CW'(1)) state_next = div_ret;
      kgb_pkg::ST_CORR:  state_next = kgb_pkg::ST_ANG2;
      kgb_pkg::ST_ANG2:  state_next = kgb_pkg::ST_INNOV;
      kgb_pkg::ST_INNOV: state_next = kgb_pkg::ST_RATE2;
      kgb_pkg::ST_RATE2: state_next = kgb_pkg::ST_BIAS;
      kgb_pkg::ST_BIAS:  state_next = kgb_pkg::ST_POST1;
      kgb_pkg::ST_POST1: state_next = kgb_pkg::ST_POST2;
      kgb_pkg::ST_POST2: state_next = kgb_pkg::ST_POST3;
      kgb_pkg::ST_POST3: state_next = kgb_pkg::ST_POST4;
      kgb_pkg::ST_POST4: state_next = kgb_pkg::ST_POST5;
      kgb_pkg::ST_POST5: state_next = kgb_pkg::ST_OUT;
      kgb_pkg::ST_OUT:   if (out_load) state_next = kgb_pkg::ST_IDLE;
      default:           state_next = kgb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kgb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.angle_estimate <= out_sat(angle);
      out_ch.rate_estimate  <= out_sat(rate);
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      q_reg <= kgb_pkg::PROCESS_NOISE_RST;
      r_reg <= kgb_pkg::MEASURE_NOISE_RST;
      angle <= '0;
      bias  <= '0;
      p11   <= sat_w({{(IW-kgb_pkg::REG_BITS){1'b0}}, kgb_pkg::MEASURE_NOISE_RST});
      p13   <= '0;
      p31   <= '0;
      p33   <= '0;
    end else if (cfg_hit) begin
      if (cfg_idx == kgb_pkg::REG_PROCESS_NOISE) begin
        q_reg <= cfg_data;
        p11   <= rv;
      end else begin
        r_reg <= cfg_data;
        p11   <= sat_w({{(IW-kgb_pkg::REG_BITS){1'b0}}, cfg_data});
      end
      angle <= '0;
      bias  <= '0;
      p13   <= '0;
      p31   <= '0;
      p33   <= '0;
    end else begin
      case (state)
        kgb_pkg::ST_IDLE: begin
          acc <= in_ch.accel_angle;
          gyr <= in_ch.gyro_rate;
          dt  <= in_ch.time_step;
        end
        kgb_pkg::ST_RATE:
          rate <= sat_w({{(IW-kgb_pkg::GYR_BITS){gyr[kgb_pkg::GYR_BITS-1]}}, gyr} - ext(bias));
        kgb_pkg::ST_ANG:   angle <= sat_w(ext(angle) + ext(mr));
        kgb_pkg::ST_P33DT: p33dt <= mr;
        kgb_pkg::ST_P11A:  p11 <= sat_w(ext(p11) - ext(mr));
        kgb_pkg::ST_P11B:  p11 <= sat_w(ext(p11) + ext(mr));
        kgb_pkg::ST_P11C:  p11 <= sat_w(ext(p11) - ext(mr));
        kgb_pkg::ST_COV: begin
          p11 <= sat_w(ext(p11) + ext(qv));
          p13 <= sat_w(ext(p13) - ext(p33dt));
          p21 <= sat_w(ext(p33dt) - ext(p31));
          p31 <= sat_w(ext(p31) - ext(p33dt));
          p33 <= sat_w(ext(p33) + ext(qv));
        end
        kgb_pkg::ST_DEN:   den <= (dsum < 1) ? W'(1) : dsum;
        kgb_pkg::ST_K1, kgb_pkg::ST_K2, kgb_pkg::ST_K3: begin
          num     <= {div_mag, {F{1'b0}}} + NW'(den >> 1);
          rem     <= '0;
          quo     <= '0;
          cnt     <= CW'(NW);
          div_neg <= div_src[W-1];
          div_ret <= (state == kgb_pkg::ST_K1) ? kgb_pkg::ST_K2 :
                     (state == kgb_pkg::ST_K2) ? kgb_pkg::ST_K3 : kgb_pkg::ST_CORR;
        end
        kgb_pkg::ST_DIV: begin
          num <= num << 1;
          rem <= qbit ? diff[W-1:0] : rem2[W-1:0];
          quo <= {quo[NW-2:0], qbit};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            case (div_ret)
              kgb_pkg::ST_K2: k1 <= kres;
              kgb_pkg::ST_K3: k2 <= kres;
              default:        k3 <= kres;
            endcase
          end
        end
        kgb_pkg::ST_ANG2:  angle <= sat_w(ext(angle) + ext(mr));
        kgb_pkg::ST_INNOV: innov <= acc_err;
        kgb_pkg::ST_BIAS: begin
          rate <= sat_w(ext(rate) + ext(mr));
          omk  <= sat_w(ONE_X - ext(k1));
        end
        kgb_pkg::ST_POST1: bias <= sat_w(ext(bias) + ext(mr));
        kgb_pkg::ST_POST2: p11 <= mr;
        kgb_pkg::ST_POST3: p13 <= mr;
        kgb_pkg::ST_POST4: p31 <= sat_w(ext(p31) - ext(mr));
        kgb_pkg::ST_POST5: p33 <= sat_w(ext(p33) - ext(mr));
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kgb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "tilt_kalman_gyro_bias_unit_defines.svh"
module kgb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_angle,
  input wire logic [31:0] out_rate
);

  logic out_stall;

  assign out_stall = !rst && out_valid && !out_ready;

  `KGB_ASSERT_NEXT(a_out_hold, clk, out_stall, out_valid)
  `KGB_ASSERT_NEXT(a_out_stable, clk, out_stall, $stable(out_angle) && $stable(out_rate))
  `KGB_ASSERT_NEXT(a_busy_after_accept, clk, !rst && in_valid && in_ready, !in_ready)
  `KGB_ASSERT_NEXT(a_reset_clears, clk, rst, !out_valid && in_ready)

endmodule

bind tilt_kalman_gyro_bias_unit kgb_checker u_kgb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_angle (out_ch.angle_estimate),
  .out_rate  (out_ch.rate_estimate)
);
`default_nettype wire

FILE: bench/tilt_kalman_gyro_bias_unit_test.sv
`timescale 1ns / 1ps
module tilt_kalman_gyro_bias_unit_test;

  localparam int LATENCY = 167;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int N_RANDOM = 2000;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [kgb_pkg::IDX_BITS-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [kgb_pkg::IDX_BITS-1:0] REG_UNMAPPED_B = 2'd3;

  typedef struct {
    logic signed [kgb_pkg::ACC_BITS-1:0] acc;
    logic signed [kgb_pkg::GYR_BITS-1:0] gyr;
    logic [kgb_pkg::DT_BITS-1:0] dt;
    bit has_fixed;
    logic signed [kgb_pkg::OUT_BITS-1:0] fixed_angle;
    logic signed [kgb_pkg::OUT_BITS-1:0] fixed_rate;
  } stim_row_t;

  typedef struct {
    logic signed [kgb_pkg::OUT_BITS-1:0] angle;
    logic signed [kgb_pkg::OUT_BITS-1:0] rate;
    bit has_fixed;
    logic signed [kgb_pkg::OUT_BITS-1:0] fixed_angle;
    logic signed [kgb_pkg::OUT_BITS-1:0] fixed_rate;
  } estimate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [kgb_pkg::IDX_BITS-1:0] cfg_idx = '0;
  logic [kgb_pkg::REG_BITS-1:0] cfg_data = '0;

  kgb_in_if in_ch();
  kgb_out_if out_ch();

  tilt_kalman_gyro_bias_unit u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  longint q_reg, r_reg;
  longint angle_s, bias_s, p11, p13, p31, p33;

  estimate_t pending_estimates[$];
  int mismatches = 0;
  longint cycles = 0;
  bit timed_out = 0;
  bit rx_hold = 0;
  bit steady = 0;

  function automatic longint sat(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint sat_mag(logic [127:0] m, bit neg);
    logic [127:0] lim;
    lim = neg ? 128'd2147483648 : 128'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] ma, mb, p;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    p = ((ma * mb) + (128'd1 << 15)) >> 16;
    return sat_mag(p, neg);
  endfunction

  function automatic longint qdiv(longint p, longint den);
    logic [127:0] mp, q;
    bit neg;
    neg = p < 0;
    mp = p < 0 ? 128'(-p) : 128'(p);
    q = ((mp << 16) + 128'(den >> 1)) / 128'(den);
    return sat_mag(q, neg);
  endfunction

  function automatic void filter_restart();
    angle_s = 0; bias_s = 0; p11 = sat(r_reg); p13 = 0; p31 = 0; p33 = 0;
  endfunction

  function automatic void apply_register(logic [kgb_pkg::IDX_BITS-1:0] idx,
                                         logic [kgb_pkg::REG_BITS-1:0] v);
    if (idx == kgb_pkg::REG_PROCESS_NOISE) q_reg = v;
    else if (idx == kgb_pkg::REG_MEASURE_NOISE) r_reg = v;
    else return;
    filter_restart();
  endfunction

  function automatic estimate_t kalman_update(stim_row_t s);
    longint acc, gyr, dt, rate, p21, p33dt, den, k1, k2, k3, innov, omk;
    estimate_t e;
    acc = s.acc; gyr = s.gyr; dt = longint'(s.dt);
    rate = sat(gyr - bias_s);
    angle_s = sat(angle_s + qmul(rate, dt));
    p33dt = qmul(p33, dt);
    p11 = sat(p11 - qmul(p31, dt));
    p11 = sat(p11 + qmul(p33dt, dt));
    p11 = sat(p11 - qmul(p13, dt));
    p11 = sat(p11 + q_reg);
    p13 = sat(p13 - p33dt);
    p21 = sat(p33dt - p31);
    p31 = sat(p31 - p33dt);
    p33 = sat(p33 + q_reg);
    den = sat(p11 + r_reg);
    if (den < 1) den = 1;
    k1 = qdiv(p11, den);
    k2 = qdiv(p21, den);
    k3 = qdiv(p31, den);
    angle_s = sat(angle_s + qmul(k1, sat(acc - angle_s)));
    innov = sat(acc - angle_s);
    rate = sat(rate + qmul(k2, innov));
    bias_s = sat(bias_s + qmul(k3, innov));
    omk = sat(65536 - k1);
    p11 = qmul(omk, p11);
    p13 = qmul(omk, p13);
    p31 = sat(p31 - qmul(p11, k3));
    p33 = sat(p33 - qmul(p13, k3));
    e.angle = angle_s[31:0];
    e.rate = rate[31:0];
    e.has_fixed = s.has_fixed;
    e.fixed_angle = s.fixed_angle;
    e.fixed_rate = s.fixed_rate;
    return e;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT && !timed_out) begin
      timed_out <= 1;
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    estimate_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: angle %0d rate %0d",
                                       out_ch.angle_estimate, out_ch.rate_estimate);
      end else begin
        e = pending_estimates.pop_front();
        if (e.has_fixed && (e.fixed_angle !== e.angle || e.fixed_rate !== e.rate)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row mismatch: angle exp %0d pred %0d, rate exp %0d pred %0d",
                     e.fixed_angle, e.angle, e.fixed_rate, e.rate);
        end
        if (out_ch.angle_estimate !== e.angle || out_ch.rate_estimate !== e.rate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle exp %0d got %0d, rate exp %0d got %0d",
                     e.angle, out_ch.angle_estimate, e.rate, out_ch.rate_estimate);
        end
      end
    end
  end

  task automatic send_item(stim_row_t s);
    while (!steady && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.accel_angle <= s.acc;
    in_ch.gyro_rate <= s.gyr;
    in_ch.time_step <= s.dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_estimates.push_back(kalman_update(s));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_register(logic [kgb_pkg::IDX_BITS-1:0] idx,
                                logic [kgb_pkg::REG_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, v);
    @(posedge clk);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t s;
    int k;
    k = $urandom_range(9);
    s.has_fixed = 0;
    s.acc = $signed(25'($urandom_range(23592960))) - 25'sd11796480;
    s.gyr = $signed(28'($urandom_range(262144000))) - 28'sd131072000;
    s.dt = (k < 6) ? 17'($urandom_range(1000)) : 17'($urandom_range(65536));
    if (k == 9) s.dt = 17'($urandom);
    if (k == 8) begin
      s.acc = 25'($urandom);
      s.gyr = 28'($urandom);
    end
    return s;
  endfunction

  stim_row_t table_rows[$];

  initial begin
    q_reg = kgb_pkg::PROCESS_NOISE_RST;
    r_reg = kgb_pkg::MEASURE_NOISE_RST;
    filter_restart();
    in_ch.valid = 1'b0;
    in_ch.accel_angle = '0;
    in_ch.gyro_rate = '0;
    in_ch.time_step = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero inputs from reset leave the angle at zero and the rate at zero.
    table_rows.push_back('{25'sd0, 28'sd0, 17'd0, 1, 32'sd0, 32'sd0});
    table_rows.push_back('{25'sd11796480, 28'sd131072000, 17'd65536, 0, 0, 0});
    table_rows.push_back('{-25'sd11796480, -28'sd131072000, 17'd65536, 0, 0, 0});
    table_rows.push_back('{25'sd11796480, -28'sd131072000, 17'd0, 0, 0, 0});
    table_rows.push_back('{-25'sd16777216, 28'sd134217727, 17'd131071, 0, 0, 0});
    table_rows.push_back('{25'sd16777215, -28'sd134217728, 17'd131071, 0, 0, 0});
    table_rows.push_back('{25'sd65536, 28'sd65536, 17'd1, 0, 0, 0});
    foreach (table_rows[i]) send_item(table_rows[i]);
    drain();

    write_register(kgb_pkg::REG_PROCESS_NOISE, 31'h7fffffff);
    write_register(kgb_pkg::REG_MEASURE_NOISE, 31'd1);
    for (int i = 0; i < 6; i++) send_item(random_row());
    drain();
    write_register(kgb_pkg::REG_PROCESS_NOISE, 31'd0);
    write_register(kgb_pkg::REG_MEASURE_NOISE, 31'h7fffffff);
    write_register(REG_UNMAPPED_A, 31'd12345);
    write_register(REG_UNMAPPED_B, 31'd777);
    for (int i = 0; i < 6; i++) send_item(random_row());
    drain();
    write_register(kgb_pkg::REG_PROCESS_NOISE, kgb_pkg::PROCESS_NOISE_RST);
    write_register(kgb_pkg::REG_MEASURE_NOISE, kgb_pkg::MEASURE_NOISE_RST);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 400 == 399) begin
        drain();
        write_register(kgb_pkg::REG_PROCESS_NOISE, 31'($urandom_range(5000)));
        write_register(kgb_pkg::REG_MEASURE_NOISE, 31'($urandom_range(100000, 1)));
      end
      steady = (n >= 600 && n < 800);
      if (n == 1000) begin
        fork
          begin
            rx_hold = 1;
            repeat (2000) @(posedge clk);
            rx_hold = 0;
          end
        join_none
      end
      if (n == 1500) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_estimates.size() != 0) @(posedge clk);
      end
      send_item(random_row());
    end
    steady = 0;
    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
